@@ sv/uart_text_command_interpreter_core_macros.svh @@
// Assertion macros shared by the command interpreter RTL.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef UART_TEXT_COMMAND_INTERPRETER_CORE_MACROS_SVH
`define UART_TEXT_COMMAND_INTERPRETER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define UTCI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utci: same-cycle check failed");

// Next-cycle implication.
`define UTCI_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utci: next-cycle check failed");

`endif

@@ sv/utci_pkg.sv @@
// Package for the text command interpreter: types, character codes and message tables.
// Used by utci_bcd and uart_text_command_interpreter_core; depends on nothing.
package utci_pkg;

   localparam int LINE_CAPACITY_DEF = 30;
   localparam int MAX_RESP          = 64;
   localparam int CNT_W             = $clog2(MAX_RESP);
   localparam int NUM_W             = 32;
   localparam int DIGITS            = 10;
   localparam int PREFIX_LEN        = 8;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [63:0] KW_SET_POS = "SET_POS ";
   localparam logic [63:0] KW_SET_VEL = "SET_VEL ";
   localparam logic [63:0] KW_GET_POS = "GET_POS";
   localparam logic [63:0] KW_GET_VEL = "GET_VEL";
   localparam logic [63:0] KW_STATUS  = "STATUS";

   typedef enum logic [2:0] {
      C_OVF, C_SETPOS, C_VELOK, C_VELERR, C_GETPOS, C_GETVEL, C_STATUS, C_OTHER
   } cmd_type;

   typedef enum logic [3:0] {
      M_CMD, M_CRLF, M_OVF, M_OKPOS, M_OKVEL, M_EVEL,
      M_POS, M_VEL, M_TGT, M_SPOS, M_SVEL, M_ERR
   } msg_type;

   typedef enum logic [1:0] {K_STR, K_ECHO, K_NUM, K_END} step_kind_type;
   typedef enum logic [1:0] {N_GOAL, N_POS, N_VEL} num_src_type;

   typedef struct packed {
      step_kind_type kind;
      msg_type       msg;
      num_src_type   src;
   } step_type;

   typedef struct packed {
      logic setpos;
      logic setvel;
      logic getpos;
      logic getvel;
      logic status;
   } match_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bcd_stat_type;

   // Character i of a right-justified string literal of length len.
   function automatic logic [7:0] str_char(logic [127:0] s, logic [4:0] len, logic [3:0] i);
      int sh;
      sh = 8 * (int'(len) - 1 - int'(i));
      return s[sh +: 8];
   endfunction

   function automatic logic [4:0] msg_len(msg_type m);
      logic [4:0] l;
      unique case (m)
         M_CMD:   l = 5'd4;
         M_CRLF:  l = 5'd2;
         M_OVF:   l = 5'd16;
         M_OKPOS: l = 5'd12;
         M_OKVEL: l = 5'd12;
         M_EVEL:  l = 5'd11;
         M_POS:   l = 5'd4;
         M_VEL:   l = 5'd4;
         M_TGT:   l = 5'd7;
         M_SPOS:  l = 5'd5;
         M_SVEL:  l = 5'd5;
         M_ERR:   l = 5'd7;
         default: l = 5'd1;
      endcase
      return l;
   endfunction

   function automatic logic [7:0] msg_char(msg_type m, logic [3:0] i);
      logic [127:0] s;
      unique case (m)
         M_CMD:   s = "CMD:";
         M_CRLF:  s = "\r\n";
         M_OVF:   s = "ERROR OVERFLOW\r\n";
         M_OKPOS: s = "OK SET_POS\r\n";
         M_OKVEL: s = "OK SET_VEL\r\n";
         M_EVEL:  s = "ERROR VEL\r\n";
         M_POS:   s = "POS:";
         M_VEL:   s = "VEL:";
         M_TGT:   s = "TARGET:";
         M_SPOS:  s = " POS:";
         M_SVEL:  s = " VEL:";
         M_ERR:   s = "ERROR\r\n";
         default: s = '0;
      endcase
      return str_char(s, msg_len(m), i);
   endfunction

   // True when character c at position p keeps a keyword of length len matching.
   function automatic logic kw_ok(logic [63:0] kw, logic [3:0] len, logic [2:0] p,
                                  logic [7:0] c);
      int sh;
      sh = 8 * (int'(len) - 1 - int'(p));
      if (int'(p) >= int'(len)) return 1'b1;
      return c == kw[sh +: 8];
   endfunction

   // Response program: which segment comes at position idx for a command.
   function automatic step_type script_step(cmd_type cmd, logic [3:0] idx);
      step_type s;
      s = '{kind: K_END, msg: M_CRLF, src: N_GOAL};
      if (cmd == C_OVF) begin
         if (idx == 4'd0) s = '{kind: K_STR, msg: M_OVF, src: N_GOAL};
      end else if (idx == 4'd0) begin
         s = '{kind: K_STR, msg: M_CMD, src: N_GOAL};
      end else if (idx == 4'd1) begin
         s = '{kind: K_ECHO, msg: M_CMD, src: N_GOAL};
      end else if (idx == 4'd2) begin
         s = '{kind: K_STR, msg: M_CRLF, src: N_GOAL};
      end else begin
         unique case (cmd)
            C_SETPOS: if (idx == 4'd3) s = '{kind: K_STR, msg: M_OKPOS, src: N_GOAL};
            C_VELOK:  if (idx == 4'd3) s = '{kind: K_STR, msg: M_OKVEL, src: N_GOAL};
            C_VELERR: if (idx == 4'd3) s = '{kind: K_STR, msg: M_EVEL, src: N_GOAL};
            C_OTHER:  if (idx == 4'd3) s = '{kind: K_STR, msg: M_ERR, src: N_GOAL};
            C_GETPOS, C_GETVEL: begin
               if (idx == 4'd3) begin
                  s = '{kind: K_STR, msg: (cmd == C_GETPOS) ? M_POS : M_VEL, src: N_GOAL};
               end else if (idx == 4'd4) begin
                  s = '{kind: K_NUM, msg: M_CRLF, src: (cmd == C_GETPOS) ? N_POS : N_VEL};
               end else if (idx == 4'd5) begin
                  s = '{kind: K_STR, msg: M_CRLF, src: N_GOAL};
               end
            end
            C_STATUS: begin
               priority case (idx)
                  4'd3:    s = '{kind: K_STR, msg: M_TGT, src: N_GOAL};
                  4'd4:    s = '{kind: K_NUM, msg: M_CRLF, src: N_GOAL};
                  4'd5:    s = '{kind: K_STR, msg: M_SPOS, src: N_GOAL};
                  4'd6:    s = '{kind: K_NUM, msg: M_CRLF, src: N_POS};
                  4'd7:    s = '{kind: K_STR, msg: M_SVEL, src: N_GOAL};
                  4'd8:    s = '{kind: K_NUM, msg: M_CRLF, src: N_VEL};
                  4'd9:    s = '{kind: K_STR, msg: M_CRLF, src: N_GOAL};
                  default: s = '{kind: K_END, msg: M_CRLF, src: N_GOAL};
               endcase
            end
            default: s = '{kind: K_END, msg: M_CRLF, src: N_GOAL};
         endcase
      end
      return s;
   endfunction

endpackage

@@ sv/utci_bcd.sv @@
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on utci_pkg.
module utci_bcd
   import utci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      value,
   output bcd_stat_type          stat,
   output logic [4*DIGITS-1:0]   digits
);

   localparam int STEP_W = $clog2(NUM_W);

   logic [NUM_W-1:0]    bin_ff, bin_in;
   logic [4*DIGITS-1:0] bcd_ff, bcd_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [4*DIGITS-1:0] adj;

   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                     : bcd_ff[4*d +: 4];
      end
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {adj[4*DIGITS-2:0], bin_ff[NUM_W-1]};
         bin_in  = {bin_ff[NUM_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat   = '{busy: busy_ff, done: done_ff};
   assign digits = bcd_ff;

endmodule

@@ sv/uart_text_command_interpreter_core.sv @@
// Serial text command interpreter. Every received byte is one input item; a byte that
// does not end a line is stored (or dropped after overflow) and gives no result. A CR
// or LF that ends a non-empty line starts the response, one character per result item
// with last on the final one; the block is busy until the response is out. Characters
// go out as rsp_ready takes them, with a dispatch step per segment; SET_POS and SET_VEL
// first parse their number one character at a time, and each printed number is made by
// the shared shift-and-add-3 converter, which works one bit a cycle, and then has its
// leading zeros skipped. No clearing pass runs after reset: stale line characters are
// never read.
`include "uart_text_command_interpreter_core_macros.svh"

module uart_text_command_interpreter_core
   import utci_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic signed [31:0] req_position_now,
   input  logic signed [31:0] req_velocity_now,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_last,
   output logic signed [31:0] rsp_target_pos,
   output logic [30:0]        rsp_target_vel
);

   localparam int IDX_W = $clog2(LINE_CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE, S_PARSE, S_STEP, S_STR, S_ECHO, S_CONV, S_NSIGN, S_NDIG
   } state_type;

   // The line store holds raw characters; only positions below the length are read.
   logic [7:0] line_mem [LINE_CAPACITY];
   logic [7:0] rd_data_ff;
   logic       wr_en;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [3:0]        step_ff, step_in;
   logic [3:0]        sidx_ff, sidx_in;
   logic [IDX_W-1:0]  midx_ff, midx_in;
   logic [3:0]        dp_ff, dp_in;
   logic              started_ff, started_in;
   logic              neg_ff, neg_in;
   logic [31:0]       acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  len_ff, len_in;
   logic [IDX_W-1:0]  tlen_ff, tlen_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic              zero_ff, zero_in;
   logic              ovf_ff, ovf_in;
   match_type         match_ff, match_in;
   logic [31:0]       goal_pos_ff, goal_pos_in;
   logic [30:0]       goal_vel_ff, goal_vel_in;
   logic [31:0]       pos_ff, pos_in;
   logic [31:0]       vel_ff, vel_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        tx_ff, tx_in;
   logic              last_ff, last_in;
   logic [31:0]       tpos_ff, tpos_in;
   logic [30:0]       tvel_ff, tvel_in;

   logic              emit, emit_last, slot_free, cnt_full, is_digit;
   logic [7:0]        emit_char;
   step_type          step_cur, step_nxt;
   logic [31:0]       num_val, parsed;
   logic [3:0]        digit;
   logic              bcd_start;
   logic [31:0]       bcd_value;
   bcd_stat_type      bcd_stat;
   logic [4*DIGITS-1:0] bcd_digits;

   utci_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (bcd_value),
      .stat   (bcd_stat),
      .digits (bcd_digits)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cnt_full  = cnt_ff == {CNT_W{1'b1}};
   assign step_cur  = script_step(cmd_ff, step_ff);
   assign step_nxt  = script_step(cmd_ff, step_ff + 4'd1);
   assign is_digit  = rd_data_ff >= CH_ZERO && rd_data_ff <= CH_NINE;
   assign parsed    = neg_ff ? 32'd0 - acc_ff : acc_ff;
   assign digit     = bcd_digits[4*dp_ff +: 4];

   always_comb begin
      unique case (step_cur.src)
         N_GOAL:  num_val = goal_pos_ff;
         N_POS:   num_val = pos_ff;
         N_VEL:   num_val = vel_ff;
         default: num_val = vel_ff;
      endcase
   end
   assign bcd_value = num_val[31] ? 32'd0 - num_val : num_val;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      step_in     = step_ff;
      sidx_in     = sidx_ff;
      midx_in     = midx_ff;
      dp_in       = dp_ff;
      started_in  = started_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      len_in      = len_ff;
      tlen_in     = tlen_ff;
      n_in        = n_ff;
      zero_in     = zero_ff;
      ovf_in      = ovf_ff;
      match_in    = match_ff;
      goal_pos_in = goal_pos_ff;
      goal_vel_in = goal_vel_ff;
      pos_in      = pos_ff;
      vel_in      = vel_ff;
      wr_en       = 1'b0;
      bcd_start   = 1'b0;
      emit        = 1'b0;
      emit_last   = 1'b0;
      emit_char   = CH_NUL;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_rx_byte == CH_CR || req_rx_byte == CH_LF) begin
                  if (len_ff != '0) begin
                     pos_in   = req_position_now;
                     vel_in   = req_velocity_now;
                     len_in   = '0;
                     tlen_in  = '0;
                     zero_in  = 1'b0;
                     match_in = '1;
                     n_in     = tlen_ff;
                     cnt_in   = '0;
                     step_in  = '0;
                     neg_in   = 1'b0;
                     acc_in   = '0;
                     midx_in  = IDX_W'(PREFIX_LEN);
                     state_in = S_STEP;
                     // Keyword flags were built up as the characters arrived.
                     if (ovf_ff) begin
                        ovf_in = 1'b0;
                        cmd_in = C_OVF;
                     end else if (match_ff.setpos && tlen_ff >= IDX_W'(PREFIX_LEN)) begin
                        cmd_in   = C_SETPOS;
                        state_in = S_PARSE;
                     end else if (match_ff.setvel && tlen_ff >= IDX_W'(PREFIX_LEN)) begin
                        cmd_in   = C_VELOK;
                        state_in = S_PARSE;
                     end else if (match_ff.getpos && tlen_ff == IDX_W'(7)) begin
                        cmd_in = C_GETPOS;
                     end else if (match_ff.getvel && tlen_ff == IDX_W'(7)) begin
                        cmd_in = C_GETVEL;
                     end else if (match_ff.status && tlen_ff == IDX_W'(6)) begin
                        cmd_in = C_STATUS;
                     end else begin
                        cmd_in = C_OTHER;
                     end
                  end
               end else if (!ovf_ff) begin
                  if (len_ff < IDX_W'(LINE_CAPACITY - 1)) begin
                     wr_en  = 1'b1;
                     len_in = len_ff + 1'b1;
                     if (!zero_ff) begin
                        if (req_rx_byte == CH_NUL) zero_in = 1'b1;
                        else tlen_in = tlen_ff + 1'b1;
                     end
                     if (len_ff < IDX_W'(PREFIX_LEN)) begin
                        match_in.setpos = match_ff.setpos &
                           kw_ok(KW_SET_POS, 4'd8, len_ff[2:0], req_rx_byte);
                        match_in.setvel = match_ff.setvel &
                           kw_ok(KW_SET_VEL, 4'd8, len_ff[2:0], req_rx_byte);
                        match_in.getpos = match_ff.getpos &
                           kw_ok(KW_GET_POS, 4'd7, len_ff[2:0], req_rx_byte);
                        match_in.getvel = match_ff.getvel &
                           kw_ok(KW_GET_VEL, 4'd7, len_ff[2:0], req_rx_byte);
                        match_in.status = match_ff.status &
                           kw_ok(KW_STATUS, 4'd6, len_ff[2:0], req_rx_byte);
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
         end

         S_PARSE: begin
            // One character per cycle; the store read runs one index ahead.
            if (midx_ff < n_ff && midx_ff == IDX_W'(PREFIX_LEN) && rd_data_ff == CH_MINUS) begin
               neg_in  = 1'b1;
               midx_in = midx_ff + 1'b1;
            end else if (midx_ff < n_ff && is_digit) begin
               acc_in  = (acc_ff << 3) + (acc_ff << 1) + {24'd0, rd_data_ff - CH_ZERO};
               midx_in = midx_ff + 1'b1;
            end else begin
               if (cmd_ff == C_SETPOS) begin
                  goal_pos_in = parsed;
               end else if (parsed[31]) begin
                  cmd_in = C_VELERR;
               end else begin
                  goal_vel_in = parsed[30:0];
               end
               step_in  = '0;
               state_in = S_STEP;
            end
         end

         S_STEP: begin
            unique case (step_cur.kind)
               K_STR: begin
                  sidx_in  = '0;
                  state_in = S_STR;
               end
               K_ECHO: begin
                  midx_in = '0;
                  if (n_ff == '0) step_in = step_ff + 4'd1;
                  else state_in = S_ECHO;
               end
               K_NUM: begin
                  bcd_start  = 1'b1;
                  neg_in     = num_val[31];
                  dp_in      = 4'(DIGITS - 1);
                  started_in = 1'b0;
                  state_in   = S_CONV;
               end
               K_END: state_in = S_IDLE;
               default: state_in = S_IDLE;
            endcase
         end

         S_STR: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = msg_char(step_cur.msg, sidx_ff);
               emit_last = ({1'b0, sidx_ff} == msg_len(step_cur.msg) - 5'd1 &&
                            step_nxt.kind == K_END) || cnt_full;
               sidx_in   = sidx_ff + 4'd1;
               if ({1'b0, sidx_ff} == msg_len(step_cur.msg) - 5'd1) begin
                  step_in  = step_ff + 4'd1;
                  state_in = S_STEP;
               end
               if (emit_last) state_in = S_IDLE;
            end
         end

         S_ECHO: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = rd_data_ff;
               emit_last = cnt_full;
               midx_in   = midx_ff + 1'b1;
               if (midx_ff == n_ff - 1'b1) begin
                  step_in  = step_ff + 4'd1;
                  state_in = S_STEP;
               end
               if (cnt_full) state_in = S_IDLE;
            end
         end

         S_CONV: begin
            if (bcd_stat.done) state_in = neg_ff ? S_NSIGN : S_NDIG;
         end

         S_NSIGN: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = CH_MINUS;
               emit_last = cnt_full;
               state_in  = cnt_full ? S_IDLE : S_NDIG;
            end
         end

         S_NDIG: begin
            // Leading zeros are skipped; a zero value still prints its last digit.
            if (!started_ff && digit == 4'd0 && dp_ff != 4'd0) begin
               dp_in = dp_ff - 4'd1;
            end else if (slot_free) begin
               emit       = 1'b1;
               emit_char  = CH_ZERO + {4'd0, digit};
               emit_last  = cnt_full;
               started_in = 1'b1;
               if (dp_ff == 4'd0) begin
                  step_in  = step_ff + 4'd1;
                  state_in = S_STEP;
               end else begin
                  dp_in = dp_ff - 4'd1;
               end
               if (cnt_full) state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      tx_in        = tx_ff;
      last_in      = last_ff;
      tpos_in      = tpos_ff;
      tvel_in      = tvel_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         tx_in        = emit_char;
         last_in      = emit_last;
         tpos_in      = goal_pos_ff;
         tvel_in      = goal_vel_ff;
         cnt_in       = cnt_ff + 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) line_mem[len_ff] <= req_rx_byte;
      rd_data_ff <= line_mem[midx_in];
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      step_ff    <= step_in;
      sidx_ff    <= sidx_in;
      midx_ff    <= midx_in;
      dp_ff      <= dp_in;
      started_ff <= started_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      cnt_ff     <= cnt_in;
      n_ff       <= n_in;
      pos_ff     <= pos_in;
      vel_ff     <= vel_in;
      tx_ff      <= tx_in;
      last_ff    <= last_in;
      tpos_ff    <= tpos_in;
      tvel_ff    <= tvel_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         tlen_ff      <= '0;
         zero_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         match_ff     <= '1;
         goal_pos_ff  <= '0;
         goal_vel_ff  <= 31'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         tlen_ff      <= tlen_in;
         zero_ff      <= zero_in;
         ovf_ff       <= ovf_in;
         match_ff     <= match_in;
         goal_pos_ff  <= goal_pos_in;
         goal_vel_ff  <= goal_vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready      = state_ff == S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_byte    = tx_ff;
   assign rsp_last       = last_ff;
   assign rsp_target_pos = tpos_ff;
   assign rsp_target_vel = tvel_ff;

   // Overflow can only be raised once the store is full, and stays with a full store.
   `UTCI_ASSERT_IMP(a_ovf_full, ovf_ff, len_ff == IDX_W'(LINE_CAPACITY - 1))
   // The text length stops at the first zero byte and never passes the line length.
   `UTCI_ASSERT_IMP(a_text_len, 1'b1, tlen_ff <= len_ff)
   // The converter only finishes while the sequencer waits for it.
   `UTCI_ASSERT_IMP(a_conv_done, bcd_stat.done, state_ff == S_CONV)

endmodule
